/* hdl/fsp_pkg.sv */
package fsp_pkg;

  localparam int NUM_BITS = 16;
  localparam int LEN_BITS = 8;

  localparam logic [NUM_BITS-1:0] NUM_MAX      = {NUM_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX      = {LEN_BITS{1'b1}};
  localparam logic [NUM_BITS-1:0] PREC_DEFAULT = NUM_BITS'(6);

  localparam int FL_ZERO = 0;
  localparam int FL_SIGN = 1;
  localparam int FL_ADJ  = 2;

  localparam logic [1:0] UNC_NONE  = 2'd0;
  localparam logic [1:0] UNC_ONE   = 2'd1;
  localparam logic [1:0] UNC_TWO   = 2'd2;

  localparam logic [4:0] TC_NONE = 5'd0;
  localparam logic [4:0] TC_D    = 5'd1;
  localparam logic [4:0] TC_I    = 5'd2;
  localparam logic [4:0] TC_O    = 5'd3;
  localparam logic [4:0] TC_X    = 5'd4;
  localparam logic [4:0] TC_XU   = 5'd5;
  localparam logic [4:0] TC_U    = 5'd6;
  localparam logic [4:0] TC_C    = 5'd7;
  localparam logic [4:0] TC_S    = 5'd8;
  localparam logic [4:0] TC_F    = 5'd9;
  localparam logic [4:0] TC_E    = 5'd10;
  localparam logic [4:0] TC_EU   = 5'd11;
  localparam logic [4:0] TC_G    = 5'd12;
  localparam logic [4:0] TC_GU   = 5'd13;
  localparam logic [4:0] TC_P    = 5'd14;
  localparam logic [4:0] TC_LU   = 5'd15;
  localparam logic [4:0] TC_LD   = 5'd16;
  localparam logic [4:0] TC_LF   = 5'd17;

  typedef enum logic [2:0] {
    CL_OTHER,
    CL_DIGIT,
    CL_DOLLAR,
    CL_DOT,
    CL_PLUS,
    CL_MINUS,
    CL_LONG,
    CL_TYPE
  } fsp_class_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } fsp_in_t;

  typedef struct packed {
    logic                start;
    fsp_class_t          cls;
    logic [3:0]          dig;
    logic [4:0]          tcode;
    logic [4:0]          lcode;
  } fsp_item_t;

  typedef struct packed {
    logic                spec_valid;
    logic [LEN_BITS-1:0] spec_length;
    logic [1:0]          unconsumed;
    logic [NUM_BITS-1:0] arg_position;
    logic                zero_fill;
    logic                force_sign;
    logic                adjust_flag;
    logic [NUM_BITS-1:0] field_width;
    logic [NUM_BITS-1:0] precision;
    logic [4:0]          type_code;
  } fsp_out_t;

endpackage

/* hdl/fsp_front.sv */
module fsp_front (
  input  fsp_pkg::fsp_in_t   in_data,
  output fsp_pkg::fsp_item_t item
);

  always_comb begin
    item.start = in_data.start_req;
    item.dig   = in_data.ch[3:0];
    item.tcode = fsp_pkg::TC_NONE;
    item.lcode = fsp_pkg::TC_NONE;
    item.cls   = fsp_pkg::CL_OTHER;
    unique case (in_data.ch) inside
      ["0":"9"]: item.cls = fsp_pkg::CL_DIGIT;
      "$":       item.cls = fsp_pkg::CL_DOLLAR;
      ".":       item.cls = fsp_pkg::CL_DOT;
      "+":       item.cls = fsp_pkg::CL_PLUS;
      "-":       item.cls = fsp_pkg::CL_MINUS;
      "l":       item.cls = fsp_pkg::CL_LONG;
      "d": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_D;
        item.lcode = fsp_pkg::TC_LD;
      end
      "i": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_I;
      end
      "o": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_O;
      end
      "x": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_X;
      end
      "X": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_XU;
      end
      "u": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_U;
        item.lcode = fsp_pkg::TC_LU;
      end
      "c": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_C;
      end
      "s": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_S;
      end
      "f": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_F;
        item.lcode = fsp_pkg::TC_LF;
      end
      "e": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_E;
      end
      "E": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_EU;
      end
      "g": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_G;
      end
      "G": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_GU;
      end
      "p": begin
        item.cls   = fsp_pkg::CL_TYPE;
        item.tcode = fsp_pkg::TC_P;
      end
      default: item.cls = fsp_pkg::CL_OTHER;
    endcase
  end

endmodule

/* hdl/fsp_queue.sv */
module fsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fsp_pkg::fsp_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output fsp_pkg::fsp_item_t pop_item
);

  fsp_pkg::fsp_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hdl/fsp_back.sv */
module fsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fsp_pkg::fsp_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::fsp_out_t  out_data
);

  localparam int NB = fsp_pkg::NUM_BITS;
  localparam int LB = fsp_pkg::LEN_BITS;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_PARAM,
    PH_FLAGS,
    PH_WIDTH,
    PH_PREC
  } phase_t;

  typedef enum logic [1:0] {
    HD_NONE,
    HD_FLAGS,
    HD_WIDTH,
    HD_PREC
  } handler_t;

  phase_t            phase_r, phase_nxt;
  logic [NB-1:0]     acc_r, acc_nxt;
  logic              allz_r, allz_nxt;
  logic              lead_r, lead_nxt;
  logic [NB-1:0]     pos_r, pos_nxt;
  logic [2:0]        flags_r, flags_nxt;
  logic [NB-1:0]     width_r, width_nxt;
  logic [NB-1:0]     prec_r, prec_nxt;
  logic [LB-1:0]     count_r, count_nxt;
  logic              pl_r, pl_nxt;
  logic              out_valid_r;
  fsp_pkg::fsp_out_t out_data_r;
  fsp_pkg::fsp_out_t res;

  handler_t   hd;
  logic       tail_dot;
  logic       emit;
  logic [1:0] emit_unc;
  logic [4:0] emit_type;
  logic       is_dig;
  logic       slot_free;

  function automatic logic [NB-1:0] sat_num(input logic [NB-1:0] acc, input logic [3:0] d);
    logic [NB+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NB{1'b0}}, d};
    if (v > {4'b0000, fsp_pkg::NUM_MAX}) begin
      return fsp_pkg::NUM_MAX;
    end
    return v[NB-1:0];
  endfunction

  function automatic logic [LB-1:0] sat_inc(input logic [LB-1:0] c);
    return (c == fsp_pkg::LEN_MAX) ? c : c + LB'(1);
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && slot_free;
  assign is_dig    = (q_item.cls == fsp_pkg::CL_DIGIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    allz_nxt  = allz_r;
    lead_nxt  = lead_r;
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    count_nxt = count_r;
    pl_nxt    = pl_r;
    hd        = HD_NONE;
    tail_dot  = 1'b0;
    emit      = 1'b0;
    emit_unc  = fsp_pkg::UNC_NONE;
    emit_type = fsp_pkg::TC_NONE;

    if (q_pop) begin
      if (q_item.start) begin
        phase_nxt = PH_START;
        acc_nxt   = '0;
        allz_nxt  = 1'b1;
        lead_nxt  = 1'b0;
        pos_nxt   = '0;
        flags_nxt = 3'b000;
        width_nxt = '0;
        prec_nxt  = fsp_pkg::PREC_DEFAULT;
        count_nxt = '0;
        pl_nxt    = 1'b0;
      end
      if (phase_nxt != PH_IDLE) begin
        if (pl_nxt) begin
          if (q_item.lcode == fsp_pkg::TC_NONE) begin
            emit     = 1'b1;
            emit_unc = fsp_pkg::UNC_TWO;
          end else begin
            count_nxt = sat_inc(sat_inc(count_nxt));
            emit      = 1'b1;
            emit_type = q_item.lcode;
          end
        end else begin
          unique case (phase_nxt)
            PH_START: begin
              if (is_dig) begin
                lead_nxt  = (q_item.dig == 4'd0);
                allz_nxt  = (q_item.dig == 4'd0);
                acc_nxt   = NB'(q_item.dig);
                phase_nxt = PH_PARAM;
                count_nxt = sat_inc(count_nxt);
              end else begin
                phase_nxt = PH_FLAGS;
                hd        = HD_FLAGS;
              end
            end
            PH_PARAM: begin
              if (is_dig) begin
                acc_nxt   = sat_num(acc_nxt, q_item.dig);
                allz_nxt  = allz_nxt && (q_item.dig == 4'd0);
                count_nxt = sat_inc(count_nxt);
              end else if (q_item.cls == fsp_pkg::CL_DOLLAR) begin
                pos_nxt   = acc_nxt;
                phase_nxt = PH_FLAGS;
                count_nxt = sat_inc(count_nxt);
              end else begin
                if (lead_nxt) begin
                  flags_nxt[fsp_pkg::FL_ZERO] = 1'b1;
                end
                if (allz_nxt) begin
                  phase_nxt = PH_FLAGS;
                  hd        = HD_FLAGS;
                end else begin
                  width_nxt = acc_nxt;
                  phase_nxt = PH_WIDTH;
                  hd        = HD_WIDTH;
                end
              end
            end
            PH_FLAGS: hd = HD_FLAGS;
            PH_WIDTH: hd = HD_WIDTH;
            PH_PREC:  hd = HD_PREC;
            default:  hd = HD_NONE;
          endcase

          unique case (hd)
            HD_FLAGS: begin
              if (is_dig && q_item.dig == 4'd0) begin
                flags_nxt[fsp_pkg::FL_ZERO] = 1'b1;
                count_nxt = sat_inc(count_nxt);
              end else if (q_item.cls == fsp_pkg::CL_PLUS) begin
                flags_nxt[fsp_pkg::FL_SIGN] = 1'b1;
                count_nxt = sat_inc(count_nxt);
              end else if (q_item.cls == fsp_pkg::CL_MINUS) begin
                flags_nxt[fsp_pkg::FL_ADJ] = 1'b1;
                count_nxt = sat_inc(count_nxt);
              end else if (is_dig) begin
                width_nxt = NB'(q_item.dig);
                phase_nxt = PH_WIDTH;
                count_nxt = sat_inc(count_nxt);
              end else begin
                tail_dot = 1'b1;
              end
            end
            HD_WIDTH: begin
              if (is_dig) begin
                width_nxt = sat_num(width_nxt, q_item.dig);
                count_nxt = sat_inc(count_nxt);
              end else begin
                tail_dot = 1'b1;
              end
            end
            HD_PREC: begin
              if (is_dig) begin
                prec_nxt  = sat_num(prec_nxt, q_item.dig);
                count_nxt = sat_inc(count_nxt);
              end else if (q_item.cls == fsp_pkg::CL_DOT) begin
                emit     = 1'b1;
                emit_unc = fsp_pkg::UNC_ONE;
              end else begin
                tail_dot = 1'b1;
              end
            end
            default: tail_dot = 1'b0;
          endcase

          if (tail_dot) begin
            unique case (q_item.cls)
              fsp_pkg::CL_DOT: begin
                prec_nxt  = '0;
                phase_nxt = PH_PREC;
                count_nxt = sat_inc(count_nxt);
              end
              fsp_pkg::CL_TYPE: begin
                count_nxt = sat_inc(count_nxt);
                emit      = 1'b1;
                emit_type = q_item.tcode;
              end
              fsp_pkg::CL_LONG: pl_nxt = 1'b1;
              default: begin
                emit     = 1'b1;
                emit_unc = fsp_pkg::UNC_ONE;
              end
            endcase
          end
        end
      end
      if (emit) begin
        phase_nxt = PH_IDLE;
        pl_nxt    = 1'b0;
      end
    end
  end

  always_comb begin
    res.spec_valid   = (count_nxt != '0);
    res.spec_length  = count_nxt;
    res.unconsumed   = emit_unc;
    res.arg_position = res.spec_valid ? pos_nxt : '0;
    res.zero_fill    = res.spec_valid && flags_nxt[fsp_pkg::FL_ZERO];
    res.force_sign   = res.spec_valid && flags_nxt[fsp_pkg::FL_SIGN];
    res.adjust_flag  = res.spec_valid && flags_nxt[fsp_pkg::FL_ADJ];
    res.field_width  = res.spec_valid ? width_nxt : '0;
    res.precision    = res.spec_valid ? prec_nxt : '0;
    res.type_code    = res.spec_valid ? emit_type : fsp_pkg::TC_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      allz_r      <= 1'b1;
      lead_r      <= 1'b0;
      pos_r       <= '0;
      flags_r     <= 3'b000;
      width_r     <= '0;
      prec_r      <= fsp_pkg::PREC_DEFAULT;
      count_r     <= '0;
      pl_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      allz_r  <= allz_nxt;
      lead_r  <= lead_nxt;
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      width_r <= width_nxt;
      prec_r  <= prec_nxt;
      count_r <= count_nxt;
      pl_r    <= pl_nxt;
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hdl/format_spec_parser.sv */
// Format specifier parser.
// Input channel (in_valid / in_stall / in_data): one character of the text
// after a percent sign per transaction, with start_req marking the first
// character of a new specifier. A NUL character ends the string.
// Result channel (out_valid / out_stall / out_data): at most one result per
// input transaction, issued when a character ends the specifier (a type
// letter, an l-type, or a character that cannot extend it).
// Throughput: one character per clock while in_stall is low. Each character
// is classified on entry and placed in a two-entry queue; the parser state
// machine takes one queued character per clock whenever its output register
// is free or being drained in the same cycle.
// With the queue empty, the character that completes a specifier is written
// into the queue, the parser takes it from there, and the result register
// loads, so out_valid rises.
// Reset: parser idle, queue empty, no result pending; characters without
// start_req are dropped until a start.
// Stall: a stalled result holds in the output register, the parser stops,
// and the queue absorbs up to two characters before in_stall rises.
module format_spec_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fsp_pkg::fsp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fsp_pkg::fsp_out_t out_data
);

  fsp_pkg::fsp_item_t in_item;
  fsp_pkg::fsp_item_t q_item;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;

  assign in_stall = q_full;

  fsp_front u_front (
    .in_data (in_data),
    .item    (in_item)
  );

  fsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
